>>> hw/rtl/hex_record_to_segment_converter_top_macros.svh
// Assertion macros for the hex record converter checker
`ifndef HEX_RECORD_TO_SEGMENT_CONVERTER_TOP_MACROS_SVH
`define HEX_RECORD_TO_SEGMENT_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define HRSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hrsc: same-cycle property failed");

// next-cycle implication, sampled on clock, off during reset
`define HRSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hrsc: next-cycle property failed");

`endif

>>> hw/rtl/hrsc_pkg.sv
// Shared types, constants and helpers for the hex record converter
package hrsc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int JOB_BYTES = 5;
   localparam int POS_W = 10;

   localparam logic [POS_W-1:0] POS_MAX      = '1;
   localparam logic [POS_W-1:0] POS_TYPE_END = POS_W'(8);
   localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(10);

   localparam logic [3:0] POS_LEN_LO  = 4'd2;
   localparam logic [3:0] POS_ADDR_HI = 4'd4;
   localparam logic [3:0] POS_ADDR_LO = 4'd6;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [7:0] REC_TYPE_LAST = 8'h01;
   localparam logic [7:0] SEG_LOAD      = 8'h01;
   localparam logic [7:0] SEG_ENTRY     = 8'h02;
   localparam logic [7:0] LEN_BIAS      = 8'h02;

   typedef struct packed {
      logic [7:0] text_char;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       bad_format;
   } rsp_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      bad;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

   // bit 4: digit valid, bits 3:0: value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/hrsc_front.sv
// Front end: record tokeniser, field capture and job classification
module hrsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  hrsc_pkg::req_type     req_data,
   output hrsc_pkg::job_push_type job_out
);
   import hrsc_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       hn_ff, hn_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       ah_ff, ah_in;
   logic [7:0]       al_ff, al_in;
   logic             ier_ff, ier_in;
   logic [7:0]       bl_ff, bl_in;
   logic             ec_ff, ec_in;
   logic [7:0]       el_ff, el_in;
   logic [7:0]       eh_ff, eh_in;
   logic             failed_ff, failed_in;

   logic [7:0] c;
   logic       ws;
   logic [4:0] hv;
   logic [7:0] b;
   logic       err;
   logic       bad;
   logic       hdr;
   logic       have;
   job_type    job;

   assign c  = req_data.text_char;
   assign ws = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   assign hv = hex_decode(c);
   assign b  = {hn_ff, hv[3:0]};

   always_comb begin
      pos_in = pos_ff;
      hn_in = hn_ff;
      len_in = len_ff;
      ah_in = ah_ff;
      al_in = al_ff;
      ier_in = ier_ff;
      bl_in = bl_ff;
      ec_in = ec_ff;
      el_in = el_ff;
      eh_in = eh_ff;
      failed_in = failed_ff;
      err = 1'b0;
      bad = 1'b0;
      hdr = 1'b0;
      have = 1'b0;
      job = '0;
      if (!failed_ff) begin
         if (!ws) begin
            if (pos_ff != POS_MAX) pos_in = pos_ff + POS_W'(1);
            if (pos_ff == '0) begin
               if (c != CHAR_COLON) err = 1'b1;
            end else if (pos_ff <= POS_TYPE_END) begin
               if (!hv[4]) begin
                  err = 1'b1;
               end else if (pos_ff[0]) begin
                  hn_in = hv[3:0];
               end else begin
                  case (pos_ff[3:0])
                     POS_LEN_LO:  len_in = b;
                     POS_ADDR_HI: ah_in = b;
                     POS_ADDR_LO: begin
                        al_in = b;
                        if (!ec_ff) begin
                           ec_in = 1'b1;
                           el_in = b;
                           eh_in = ah_ff;
                        end
                     end
                     default: begin
                        if (b > REC_TYPE_LAST) begin
                           err = 1'b1;
                        end else begin
                           ier_in = b[0];
                           bl_in = b[0] ? 8'd0 : len_ff;
                        end
                     end
                  endcase
               end
            end else begin
               if (!ier_ff && bl_ff != 8'd0) begin
                  if (!hv[4]) begin
                     err = 1'b1;
                  end else if (pos_ff[0]) begin
                     hn_in = hv[3:0];
                  end else begin
                     bl_in = bl_ff - 8'd1;
                     have = 1'b1;
                  end
               end
               if (pos_ff == POS_HDR_END) begin
                  hdr = 1'b1;
                  if (ier_ff) begin
                     job.bytes[0] = SEG_ENTRY;
                     job.bytes[1] = SEG_ENTRY;
                     job.bytes[2] = el_ff;
                     job.bytes[3] = eh_ff;
                  end else begin
                     job.bytes[0] = SEG_LOAD;
                     job.bytes[1] = len_ff + LEN_BIAS;
                     job.bytes[2] = al_ff;
                     job.bytes[3] = ah_ff;
                  end
               end
               if (have) begin
                  job.bytes[hdr ? 3'd4 : 3'd0] = b;
               end
               job.count = (hdr ? 3'd4 : 3'd0) + (have ? 3'd1 : 3'd0);
            end
         end
         if (!err && (ws || req_data.stream_end) && pos_in != '0) begin
            bad = (pos_in <= POS_HDR_END) || (bl_in != 8'd0);
            pos_in = '0;
            bl_in = 8'd0;
            ier_in = 1'b0;
            len_in = 8'd0;
            if (bad) err = 1'b1;
         end
         if (err) begin
            failed_in = 1'b1;
            job = '0;
            job.count = 3'd1;
            job.bad = 1'b1;
         end
      end
   end

   assign job_out.push = take && (job.count != 3'd0);
   assign job_out.job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hn_ff <= '0;
         len_ff <= '0;
         ah_ff <= '0;
         al_ff <= '0;
         ier_ff <= 1'b0;
         bl_ff <= '0;
         ec_ff <= 1'b0;
         el_ff <= '0;
         eh_ff <= '0;
         failed_ff <= 1'b0;
      end else if (take) begin
         pos_ff <= pos_in;
         hn_ff <= hn_in;
         len_ff <= len_in;
         ah_ff <= ah_in;
         al_ff <= al_in;
         ier_ff <= ier_in;
         bl_ff <= bl_in;
         ec_ff <= ec_in;
         el_ff <= el_in;
         eh_ff <= eh_in;
         failed_ff <= failed_in;
      end
   end

endmodule

>>> hw/rtl/hrsc_queue.sv
// Job queue between front end and back end
module hrsc_queue #(
   parameter int DEPTH = hrsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hrsc_pkg::job_push_type wr,
   input  logic                   rd_pop,
   output hrsc_pkg::job_type      rd_job,
   output logic                   full,
   output logic                   empty
);
   import hrsc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          q_ff [DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr;
   logic             do_rd;

   assign full   = (cnt_ff == CNT_W'(DEPTH));
   assign empty  = (cnt_ff == '0);
   assign rd_job = q_ff[rp_ff];
   assign do_wr  = wr.push && !full;
   assign do_rd  = rd_pop && !empty;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (do_wr) wp_in = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
      if (do_rd) rp_in = (rp_ff == PTR_W'(DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
      if (do_wr && !do_rd) cnt_in = cnt_ff + CNT_W'(1);
      if (do_rd && !do_wr) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) q_ff[wp_ff] <= wr.job;
   end

endmodule

>>> hw/rtl/hrsc_back.sv
// Back end: expands one job into result bytes in an output register, one per cycle unless the output stalls
module hrsc_back (
   input  logic              clock,
   input  logic              reset,
   input  hrsc_pkg::job_type job,
   input  logic              job_empty,
   output logic              job_pop,
   output hrsc_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import hrsc_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       ov_ff, ov_in;
   rsp_type    out_ff, out_in;
   logic       adv;
   logic       last;

   assign adv  = !job_empty && (!ov_ff || rsp_pop);
   assign last = (idx_ff == (job.count - 3'd1));

   always_comb begin
      idx_in = idx_ff;
      ov_in = ov_ff && !rsp_pop;
      out_in = out_ff;
      job_pop = 1'b0;
      if (adv) begin
         ov_in = 1'b1;
         out_in.out_byte = job.bytes[idx_ff];
         out_in.run_last = last;
         out_in.bad_format = job.bad;
         if (last) begin
            idx_in = '0;
            job_pop = 1'b1;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !ov_ff;

endmodule

>>> hw/rtl/hex_record_to_segment_converter_top.sv
// Top level of the hex record to load segment converter
//
//  channel | direction | handshake          | payload
//  req     | in        | req_push / req_full | req_type: text_char, stream_end
//  rsp     | out       | rsp_pop / rsp_empty | rsp_type: out_byte, run_last, bad_format
//
// One character is taken per cycle while the job queue has room.
// Back end: one result byte per cycle unless rsp_pop stalls; a header job is four bytes, five with a data byte.
// A character's bytes pass through the job queue and then the output register to the result port.
// Synchronous reset clears the parser state, queue pointers and count, and the back end index and valid flag.
// Either side may stall independently; the job queue absorbs header bursts.
module hex_record_to_segment_converter_top #(
   parameter int QUEUE_DEPTH = hrsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  hrsc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output hrsc_pkg::rsp_type rsp_data
);
   import hrsc_pkg::*;

   job_push_type wr;
   job_type      head;
   logic         q_empty;
   logic         q_pop;

   hrsc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (req_push && !req_full),
      .req_data(req_data),
      .job_out (wr)
   );

   hrsc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .rd_pop(q_pop),
      .rd_job(head),
      .full  (req_full),
      .empty (q_empty)
   );

   hrsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job      (head),
      .job_empty(q_empty),
      .job_pop  (q_pop),
      .rsp_data (rsp_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop)
   );

endmodule

>>> hw/rtl/hrsc_checker.sv
// Port-level checker for the hex record converter, with its bind
`include "hex_record_to_segment_converter_top_macros.svh"

module hrsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input hrsc_pkg::rsp_type rsp_data
);
   import hrsc_pkg::*;

   `HRSC_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

   `HRSC_ASSERT_NOW(a_err_shape, !rsp_empty && rsp_data.bad_format, rsp_data.out_byte == 8'h00 && rsp_data.run_last)

   `HRSC_ASSERT_NEXT(a_err_final, !rsp_empty && rsp_pop && rsp_data.bad_format, rsp_empty)

endmodule

bind hex_record_to_segment_converter_top hrsc_checker u_hrsc_checker (.*);

>>> dv/tb_hex_record_to_segment_converter_top.sv
`timescale 1ns / 100ps
// Self-checking testbench: streams hex text into the converter and checks every segment byte
module tb_hex_record_to_segment_converter_top;
   import hrsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int PHASE_CHARS    = 12;
   localparam int HOLD_CYCLES    = 300;

   localparam logic [7:0] REC_TYPE_DATA = 8'h00;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_VT       = 8'h0B;
   localparam logic [7:0] CHAR_FF       = 8'h0C;

   typedef logic [7:0] text_t[$];

   typedef enum int {
      BAD_NO_COLON,
      BAD_HEADER_DIGIT,
      BAD_RECORD_TYPE,
      BAD_SHORT_TOKEN,
      BAD_TRUNCATED,
      BAD_DATA_DIGIT
   } format_fault_e;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   hex_record_to_segment_converter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // parser state as the block should hold it
   logic [POS_W-1:0] tok_pos       = '0;
   logic [3:0]       tok_nibble    = '0;
   logic [7:0]       rec_len       = '0;
   logic [7:0]       addr_hi       = '0;
   logic [7:0]       addr_lo       = '0;
   logic             rec_is_end    = 1'b0;
   logic [7:0]       data_left     = '0;
   logic             entry_seen    = 1'b0;
   logic [7:0]       entry_lo      = '0;
   logic [7:0]       entry_hi      = '0;
   logic             parser_failed = 1'b0;

   rsp_type       expected_segment_bytes[$];
   format_fault_e fault_kind;
   int unsigned   send_idle_pct   = 0;
   int unsigned   pop_stall_pct   = 0;
   int unsigned   rsp_hold_cycles = 0;
   int unsigned   stall_cycles    = 0;
   int unsigned   mismatch_count  = 0;
   int unsigned   chars_sent      = 0;
   int unsigned   bytes_checked   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // bit 4 flags an uppercase hex digit
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, 4'(c - "0")};
      end
      if (c >= "A" && c <= "F") begin
         return {1'b1, 4'(c - "A" + 8'd10)};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      // letters start at 'A' less ten
      return 8'(n) + ((n < 4'd10) ? 8'h30 : 8'h37);
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(5))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_LF;
         3:       return CHAR_VT;
         4:       return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] token_junk();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_space(c));
      return c;
   endfunction

   // neither whitespace, nor an uppercase hex digit, nor a colon
   function automatic logic [7:0] odd_char();
      logic [7:0] c;
      logic [4:0] d;
      do begin
         c = token_junk();
         d = nibble_of(c);
      end while (d[4] || c == CHAR_COLON);
      return c;
   endfunction

   function automatic text_t random_bytes(input int unsigned n);
      text_t q;
      repeat (n) q.push_back(8'($urandom_range(255)));
      return q;
   endfunction

   function automatic text_t build_record(input logic [7:0] rtype, input logic [7:0] len,
         input logic [15:0] addr, input text_t data, input int unsigned tail);
      text_t tok;
      text_t field;
      tok = {CHAR_COLON};
      field = {len, addr[15:8], addr[7:0], rtype};
      foreach (data[i]) field.push_back(data[i]);
      foreach (field[i]) begin
         tok.push_back(hex_char(field[i][7:4]));
         tok.push_back(hex_char(field[i][3:0]));
      end
      repeat (2 + tail) tok.push_back(token_junk());
      return tok;
   endfunction

   function automatic void predict_segment_bytes(input req_type item);
      logic [POS_W-1:0] p;
      logic [4:0]       digit;
      logic [7:0]       b;
      logic [7:0]       seg[$];
      logic             fault;
      logic             space;
      logic             have_byte;
      fault = 1'b0;
      have_byte = 1'b0;
      space = is_space(item.text_char);
      if (parser_failed) return;
      if (!space) begin
         p = tok_pos;
         if (tok_pos != POS_MAX) tok_pos++;
         digit = nibble_of(item.text_char);
         b = {tok_nibble, digit[3:0]};
         if (p == 0) begin
            fault = (item.text_char != CHAR_COLON);
         end else if (p <= POS_TYPE_END) begin
            if (!digit[4]) begin
               fault = 1'b1;
            end else if (p[0]) begin
               tok_nibble = digit[3:0];
            end else if (p == POS_W'(POS_LEN_LO)) begin
               rec_len = b;
            end else if (p == POS_W'(POS_ADDR_HI)) begin
               addr_hi = b;
            end else if (p == POS_W'(POS_ADDR_LO)) begin
               addr_lo = b;
               if (!entry_seen) begin
                  entry_seen = 1'b1;
                  entry_lo = b;
                  entry_hi = addr_hi;
               end
            end else if (b > REC_TYPE_LAST) begin
               fault = 1'b1;
            end else begin
               rec_is_end = (b == REC_TYPE_LAST);
               data_left = rec_is_end ? 8'd0 : rec_len;
            end
         end else begin
            if (!rec_is_end && data_left != 0) begin
               if (!digit[4]) begin
                  fault = 1'b1;
               end else if (p[0]) begin
                  tok_nibble = digit[3:0];
               end else begin
                  data_left--;
                  have_byte = 1'b1;
               end
            end
            if (p == POS_HDR_END) begin
               if (rec_is_end) begin
                  seg = {SEG_ENTRY, SEG_ENTRY, entry_lo, entry_hi};
               end else begin
                  seg = {SEG_LOAD, 8'(rec_len + LEN_BIAS), addr_lo, addr_hi};
               end
            end
            if (have_byte) seg.push_back(b);
         end
      end
      if (!fault && (space || item.stream_end) && tok_pos != 0) begin
         fault = (tok_pos <= POS_HDR_END) || (data_left != 0);
         tok_pos = '0;
         data_left = '0;
         rec_is_end = 1'b0;
         rec_len = '0;
      end
      if (fault) begin
         // bytes of the offending character are dropped
         parser_failed = 1'b1;
         expected_segment_bytes.push_back('{out_byte: 8'h00, run_last: 1'b1, bad_format: 1'b1});
      end else begin
         foreach (seg[i]) begin
            expected_segment_bytes.push_back('{out_byte: seg[i],
                                               run_last: (i == seg.size() - 1),
                                               bad_format: 1'b0});
         end
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input logic closes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{text_char: c, stream_end: closes};
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_segment_bytes('{text_char: c, stream_end: closes});
      chars_sent++;
   endtask

   task automatic send_text(input text_t tok, input logic end_on_last);
      foreach (tok[i]) send_char(tok[i], end_on_last && (i == tok.size() - 1));
   endtask

   // closes the token by stream end, by whitespace ending the stream, or by plain whitespace
   task automatic send_record(input text_t tok);
      int unsigned close_kind;
      int unsigned gap;
      close_kind = $urandom_range(3);
      gap = $urandom_range(3, 1);
      send_text(tok, close_kind == 0);
      if (close_kind != 0) begin
         for (int i = 0; i < gap; i++) begin
            send_char(space_char(), close_kind == 1 && i == gap - 1);
         end
      end
   endtask

   task automatic run_random_records(input int unsigned budget);
      int unsigned start;
      logic [7:0]  len;
      text_t       none;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         if ($urandom_range(4) == 0) begin
            send_record(build_record(REC_TYPE_LAST, 8'($urandom_range(255)), 16'($urandom),
                                     none, $urandom_range(3)));
         end else begin
            len = ($urandom_range(9) == 0) ? 8'($urandom_range(24)) : 8'($urandom_range(5));
            send_record(build_record(REC_TYPE_DATA, len, 16'($urandom), random_bytes(len),
                                     $urandom_range(3)));
         end
      end
   endtask

   task automatic test_segment_extremes();
      text_t none;
      text_t digits;
      digits = {8'h00, 8'hFF, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
      send_record(build_record(REC_TYPE_DATA, 8'd0, 16'hFFFF, none, 0));
      send_record(build_record(REC_TYPE_DATA, 8'd1, 16'h0000, {8'h00}, 1));
      send_record(build_record(REC_TYPE_DATA, 8'd10, 16'hA5C3, digits, 2));
      send_record(build_record(REC_TYPE_LAST, 8'hFF, 16'hFFFF, none, 3));
   endtask

   task automatic test_separators();
      text_t none;
      text_t sep;
      sep = {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
      // a separator not taken as whitespace would open a token without a colon
      send_text(build_record(REC_TYPE_DATA, 8'd0, 16'($urandom), none, 0), 1'b0);
      foreach (sep[i]) send_char(sep[i], i == sep.size() - 1);
      // stream end closes the token; the next character opens a new one
      send_text(build_record(REC_TYPE_DATA, 8'd2, 16'($urandom), random_bytes(2), 0), 1'b1);
      send_text(build_record(REC_TYPE_LAST, 8'd0, 16'($urandom), none, 1), 1'b1);
      send_char(CHAR_SPACE, 1'b1);
      send_char(CHAR_TAB, 1'b0);
   endtask

   task automatic test_long_token();
      send_record(build_record(REC_TYPE_DATA, 8'd2, 16'($urandom), random_bytes(2), 8));
   endtask

   task automatic test_random_phases();
      send_idle_pct = 0;  pop_stall_pct = 0;  run_random_records(PHASE_CHARS);
      send_idle_pct = 83; pop_stall_pct = 0;  run_random_records(PHASE_CHARS);
      send_idle_pct = 0;  pop_stall_pct = 83; run_random_records(PHASE_CHARS);
      send_idle_pct = 36; pop_stall_pct = 36; run_random_records(PHASE_CHARS);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      // header plus six data bytes is more jobs than the queue holds
      send_record(build_record(REC_TYPE_DATA, 8'd6, 16'($urandom), random_bytes(6), 0));
      run_random_records(8);
   endtask

   task automatic test_format_error();
      text_t       tok;
      text_t       none;
      int unsigned cut;
      logic [7:0]  len;
      fault_kind = format_fault_e'($urandom_range(BAD_DATA_DIGIT));
      len = 8'($urandom_range(8, 2));
      tok = build_record(REC_TYPE_DATA, len, 16'($urandom), random_bytes(len), 0);
      case (fault_kind)
         BAD_NO_COLON: begin
            tok[0] = odd_char();
         end
         BAD_HEADER_DIGIT: begin
            tok[$urandom_range(8, 1)] = odd_char();
         end
         BAD_RECORD_TYPE: begin
            tok = build_record(8'($urandom_range(255, 2)), 8'd0, 16'($urandom), none, 0);
         end
         BAD_SHORT_TOKEN: begin
            tok = build_record(REC_TYPE_LAST, 8'd0, 16'($urandom), none, 0);
            cut = $urandom_range(10, 1);
            while (tok.size() > cut) void'(tok.pop_back());
         end
         BAD_TRUNCATED: begin
            // at eleven characters the header is due, but data bytes stay owed
            cut = $urandom_range(8 + 2 * len, 11);
            while (tok.size() > cut) void'(tok.pop_back());
         end
         default: begin
            tok[$urandom_range(8 + 2 * len, 9)] = odd_char();
         end
      endcase
      send_record(tok);
      send_idle_pct = 36;
      pop_stall_pct = 36;
      run_random_records(8);
   endtask

   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_checker
      rsp_type want;
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         bytes_checked++;
         if (expected_segment_bytes.size() == 0) begin
            $error("unexpected transfer: out_byte %02h run_last %0b bad_format %0b",
                   rsp_data.out_byte, rsp_data.run_last, rsp_data.bad_format);
            mismatch_count++;
         end else begin
            want = expected_segment_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_data.out_byte);
               mismatch_count++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_data.run_last);
               mismatch_count++;
            end
            if (rsp_data.bad_format !== want.bad_format) begin
               $error("bad_format: expected %0b, got %0b", want.bad_format,
                      rsp_data.bad_format);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no transfer for %0d cycles, %0d bytes outstanding",
               WATCHDOG_LIMIT, expected_segment_bytes.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_segment_extremes();
      test_separators();
      test_long_token();
      test_random_phases();
      test_backpressure();
      test_format_error();

      req_push <= 1'b0;
      pop_stall_pct = 0;
      while (expected_segment_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d characters, checked %0d segment bytes across four idling phases",
               chars_sent, bytes_checked);
      $display("covered boundary records, every separator, a long token, a long output hold"
               , " and the format fault %s", fault_kind.name());
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hrsc_pkg.sv
hw/rtl/hrsc_front.sv
hw/rtl/hrsc_queue.sv
hw/rtl/hrsc_back.sv
hw/rtl/hex_record_to_segment_converter_top.sv
hw/rtl/hrsc_checker.sv
dv/tb_hex_record_to_segment_converter_top.sv
